// ===== design/etfp_pkg.sv =====
// shared constants, types and state encoding for the escape-time fractal pixel block
// no dependencies; every other file in the project takes names from here by scope
package etfp_pkg;

	localparam int ROWS           = 1024;
	localparam int COLUMNS        = 1024;
	localparam int ITERATION_BITS = 12;
	localparam int FRACTION_BITS  = 28;
	localparam int VALUE_BITS     = FRACTION_BITS + 4;

	localparam int INDEX_BITS     = 10;
	localparam int STEP_BITS      = 31;
	localparam int KIND_BITS      = 2;
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 32;

	localparam int PROD_BITS      = 2 * VALUE_BITS;
	localparam int WIDE_BITS      = PROD_BITS + 1;
	localparam int PMAG_BITS      = PROD_BITS - FRACTION_BITS;
	localparam int SQRT6_SHIFT    = 30;

	// register indexes on the configuration channel
	localparam logic [CFG_INDEX_BITS-1:0] CFG_KIND      = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_ITER  = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_ORIGIN_RE = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_ORIGIN_IM = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_STEP      = 3'd4;

	// fractal kinds
	localparam logic [KIND_BITS-1:0] KIND_MANDELBROT   = 2'd0;
	localparam logic [KIND_BITS-1:0] KIND_SQRT6        = 2'd1;
	localparam logic [KIND_BITS-1:0] KIND_TRICORN      = 2'd2;
	localparam logic [KIND_BITS-1:0] KIND_BURNING_SHIP = 2'd3;

	// reset values of the registers
	localparam logic [KIND_BITS-1:0]      RST_KIND      = KIND_MANDELBROT;
	localparam logic [ITERATION_BITS-1:0] RST_MAX_ITER  = ITERATION_BITS'(64);
	localparam logic [VALUE_BITS-1:0]     RST_ORIGIN_RE = 32'hE000_0000;
	localparam logic [VALUE_BITS-1:0]     RST_ORIGIN_IM = 32'hE000_0000;
	localparam logic [STEP_BITS-1:0]      RST_STEP      = STEP_BITS'(1048576);

	// bitwise integer square root, evaluated at elaboration only
	function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
		logic [63:0] n;
		logic [63:0] res;
		logic [63:0] b;
		n   = n_in;
		res = 64'd0;
		b   = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (n >= res + b) begin
				n   = n - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	// floor(sqrt(6) * 2^30), unsigned Q2.30
	localparam logic [VALUE_BITS-1:0] SQRT6 = VALUE_BITS'(isqrt64(64'd6 << 60));

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CR,
		ST_CI,
		ST_CC,
		ST_SQR,
		ST_SQI,
		ST_PRD,
		ST_PMAG,
		ST_UPD,
		ST_DONE
	} etfp_state_t;

	typedef struct packed {
		logic [VALUE_BITS-1:0] a;
		logic [VALUE_BITS-1:0] b;
	} etfp_mul_req_t;

endpackage

// ===== design/etfp_if.sv =====
// channel interfaces: pixel input, result output and configuration write
// depends on etfp_pkg for field widths
interface etfp_in_if;
	logic                             valid;
	logic                             ready;
	logic [etfp_pkg::INDEX_BITS-1:0]  row_index;
	logic [etfp_pkg::INDEX_BITS-1:0]  column_index;

	modport source(output valid, output row_index, output column_index, input ready);
	modport sink(input valid, input row_index, input column_index, output ready);
endinterface

interface etfp_out_if;
	logic                                 valid;
	logic                                 ready;
	logic [etfp_pkg::INDEX_BITS-1:0]      out_row;
	logic [etfp_pkg::INDEX_BITS-1:0]      out_column;
	logic [etfp_pkg::ITERATION_BITS-1:0]  iteration_count;

	modport source(output valid, output out_row, output out_column,
		output iteration_count, input ready);
	modport sink(input valid, input out_row, input out_column,
		input iteration_count, output ready);
endinterface

interface etfp_cfg_if;
	logic                                 valid;
	logic                                 ready;
	logic [etfp_pkg::CFG_INDEX_BITS-1:0]  index;
	logic [etfp_pkg::CFG_DATA_BITS-1:0]   data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

// ===== design/etfp_mul.sv =====
// shared unsigned multiplier with a registered product
// depends on etfp_pkg for the operand struct and widths
module etfp_mul (
	input  logic                               clk,
	input  etfp_pkg::etfp_mul_req_t            req,
	output logic [etfp_pkg::PROD_BITS-1:0]     prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= etfp_pkg::PROD_BITS'(req.a) * etfp_pkg::PROD_BITS'(req.b);
	end

endmodule

// ===== design/escape_time_fractal_pixel_top.sv =====
// escape-time fractal pixel evaluator: sequencer, datapath and config registers
// depends on etfp_pkg, the channel interfaces in etfp_if and the shared multiplier etfp_mul
//
//  channel  dir  beat contents                                  handshake
//  pixel    in   row_index, column_index                        valid/ready
//  result   out  out_row, out_column, iteration_count           valid/ready
//  cfg      in   index, data (register write)                   valid/ready, always ready
//
// one pixel passes CR, CI and CC to set up c, then repeats the iteration states until the
// limit stops it or it escapes in PRD; each iteration steps through SQR, SQI, PRD, PMAG, UPD
// around the one 32x32 multiplier (two squares, cross product, sqrt6 scaling, update)
// reset returns the config registers to their defaults and the sequencer to idle.
// a finished result sits in the output register; the next pixel is taken while it waits,
// and only a second finished result stalls until the first beat is taken.
module escape_time_fractal_pixel_top (
	input  logic            clk,
	input  logic            arst_n,
	etfp_in_if.sink         pixel,
	etfp_out_if.source      result,
	etfp_cfg_if.sink        cfg
);

	localparam int VB = etfp_pkg::VALUE_BITS;
	localparam int FB = etfp_pkg::FRACTION_BITS;
	localparam int PB = etfp_pkg::PROD_BITS;
	localparam int WB = etfp_pkg::WIDE_BITS;
	localparam int MB = etfp_pkg::PMAG_BITS;
	localparam int IB = etfp_pkg::ITERATION_BITS;

	function automatic logic signed [VB-1:0] sat_wide(input logic signed [WB-1:0] v);
		logic hi_ones;
		logic hi_zeros;
		hi_ones  = &v[WB-1:VB-1];
		hi_zeros = ~|v[WB-1:VB-1];
		if (hi_ones || hi_zeros)
			return v[VB-1:0];
		else if (v[WB-1])
			return {1'b1, {(VB-1){1'b0}}};
		else
			return {1'b0, {(VB-1){1'b1}}};
	endfunction

	function automatic logic signed [VB-1:0] abs_sat(input logic signed [VB-1:0] v);
		if (!v[VB-1])
			return v;
		else if (v == {1'b1, {(VB-1){1'b0}}})
			return {1'b0, {(VB-1){1'b1}}};
		else
			return -v;
	endfunction

	function automatic logic signed [WB-1:0] sext_w(input logic [VB-1:0] v);
		return {{(WB-VB){v[VB-1]}}, v};
	endfunction

	function automatic logic [VB-1:0] mag_of(input logic [VB-1:0] v);
		return v[VB-1] ? (~v + 1'b1) : v;
	endfunction

	// configuration registers
	logic [etfp_pkg::KIND_BITS-1:0] kind_q;
	logic [IB-1:0]                  max_iter_q;
	logic [VB-1:0]                  origin_re_q;
	logic [VB-1:0]                  origin_im_q;
	logic [etfp_pkg::STEP_BITS-1:0] step_q;

	etfp_pkg::etfp_state_t state_q, state_d;

	logic [etfp_pkg::INDEX_BITS-1:0] row_q, col_q;
	logic signed [VB-1:0]            cr_q, ci_q, zr_q, zi_q;
	logic [VB-1:0]                   sr_q, si_q;
	logic [MB-1:0]                   p_mag_q;
	logic                            p_neg_q;
	logic [IB-1:0]                   count_q;

	logic                            res_valid_q;
	logic [etfp_pkg::INDEX_BITS-1:0] res_row_q, res_col_q;
	logic [IB-1:0]                   res_count_q;

	etfp_pkg::etfp_mul_req_t mul_req;
	logic [PB-1:0]           prod;

	logic                    accept;
	logic                    load_out;
	logic [VB-1:0]           origin_sel;
	logic signed [WB-1:0]    c_sum;
	logic [VB-1:0]           sq_val;
	logic [VB:0]             esc_sum;
	logic                    escape;
	logic [MB-1:0]           pm;
	logic [VB-1:0]           p_clamp;
	logic signed [WB-1:0]    nr_wide, ni_wide;
	logic [WB-1:0]           term_mag;
	logic                    term_neg;
	logic signed [WB-1:0]    term;
	logic signed [VB-1:0]    nr_sat, ni_sat, nr_fin, ni_fin;
	logic [IB-1:0]           count_next;
	logic                    at_limit;

	etfp_mul u_mul (
		.clk    (clk),
		.req    (mul_req),
		.prod_q (prod)
	);

	// configuration writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q      <= etfp_pkg::RST_KIND;
			max_iter_q  <= etfp_pkg::RST_MAX_ITER;
			origin_re_q <= etfp_pkg::RST_ORIGIN_RE;
			origin_im_q <= etfp_pkg::RST_ORIGIN_IM;
			step_q      <= etfp_pkg::RST_STEP;
		end else if (cfg.valid) begin
			case (cfg.index)
				etfp_pkg::CFG_KIND:      kind_q      <= cfg.data[etfp_pkg::KIND_BITS-1:0];
				etfp_pkg::CFG_MAX_ITER:  max_iter_q  <= cfg.data[IB-1:0];
				etfp_pkg::CFG_ORIGIN_RE: origin_re_q <= cfg.data[VB-1:0];
				etfp_pkg::CFG_ORIGIN_IM: origin_im_q <= cfg.data[VB-1:0];
				etfp_pkg::CFG_STEP:      step_q      <= cfg.data[etfp_pkg::STEP_BITS-1:0];
				default: ;
			endcase
		end
	end

	// datapath arithmetic around the shared multiplier
	always_comb begin
		origin_sel = (state_q == etfp_pkg::ST_CI) ? origin_re_q : origin_im_q;
		c_sum      = sext_w(origin_sel) + $signed({1'b0, prod});

		// square of a magnitude, shifted and saturated
		if (|prod[PB-1:FB+VB-1])
			sq_val = {1'b0, {(VB-1){1'b1}}};
		else
			sq_val = {1'b0, prod[FB+VB-2:FB]};
		esc_sum = {1'b0, sr_q} + {1'b0, sq_val};
		escape  = esc_sum >= ((VB+1)'(4) << FB);

		// cross product magnitude; beyond the clamp the sqrt6 result saturates anyway
		pm = prod[PB-1:FB];
		if (|pm[MB-1:VB-1])
			p_clamp = {1'b1, {(VB-1){1'b0}}};
		else
			p_clamp = pm[VB-1:0];

		nr_wide = $signed(WB'(sr_q)) - $signed(WB'(si_q)) + sext_w(cr_q);
		nr_sat  = sat_wide(nr_wide);

		if (kind_q == etfp_pkg::KIND_SQRT6) begin
			term_mag = WB'(prod[PB-1:etfp_pkg::SQRT6_SHIFT]);
			term_neg = p_neg_q;
		end else begin
			term_mag = WB'({p_mag_q, 1'b0});
			term_neg = p_neg_q ^ (kind_q == etfp_pkg::KIND_TRICORN);
		end
		term    = term_neg ? -$signed(term_mag) : $signed(term_mag);
		ni_wide = term + sext_w(ci_q);
		ni_sat  = sat_wide(ni_wide);

		if (kind_q == etfp_pkg::KIND_BURNING_SHIP) begin
			nr_fin = abs_sat(nr_sat);
			ni_fin = abs_sat(ni_sat);
		end else begin
			nr_fin = nr_sat;
			ni_fin = ni_sat;
		end

		count_next = count_q + 1'b1;
		at_limit   = count_next >= max_iter_q;
	end

	// sequencer: next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			etfp_pkg::ST_IDLE: if (pixel.valid) state_d = etfp_pkg::ST_CR;
			etfp_pkg::ST_CR:   state_d = etfp_pkg::ST_CI;
			etfp_pkg::ST_CI:   state_d = etfp_pkg::ST_CC;
			etfp_pkg::ST_CC: begin
				if (max_iter_q == '0)
					state_d = etfp_pkg::ST_DONE;
				else
					state_d = etfp_pkg::ST_SQR;
			end
			etfp_pkg::ST_SQR:  state_d = etfp_pkg::ST_SQI;
			etfp_pkg::ST_SQI:  state_d = etfp_pkg::ST_PRD;
			etfp_pkg::ST_PRD:  state_d = escape ? etfp_pkg::ST_DONE : etfp_pkg::ST_PMAG;
			etfp_pkg::ST_PMAG: state_d = etfp_pkg::ST_UPD;
			etfp_pkg::ST_UPD:  state_d = at_limit ? etfp_pkg::ST_DONE : etfp_pkg::ST_SQR;
			etfp_pkg::ST_DONE: if (!res_valid_q || result.ready) state_d = etfp_pkg::ST_IDLE;
			default:           state_d = etfp_pkg::ST_IDLE;
		endcase
	end

	// sequencer: outputs and multiplier operand selection
	always_comb begin
		pixel.ready = 1'b0;
		load_out    = 1'b0;
		mul_req     = '0;
		case (state_q)
			etfp_pkg::ST_IDLE: pixel.ready = 1'b1;
			etfp_pkg::ST_CR: begin
				mul_req.a = VB'(row_q % etfp_pkg::ROWS);
				mul_req.b = VB'(step_q);
			end
			etfp_pkg::ST_CI: begin
				mul_req.a = VB'(col_q % etfp_pkg::COLUMNS);
				mul_req.b = VB'(step_q);
			end
			etfp_pkg::ST_SQR: begin
				mul_req.a = mag_of(zr_q);
				mul_req.b = mag_of(zr_q);
			end
			etfp_pkg::ST_SQI: begin
				mul_req.a = mag_of(zi_q);
				mul_req.b = mag_of(zi_q);
			end
			etfp_pkg::ST_PRD: begin
				mul_req.a = mag_of(zi_q);
				mul_req.b = mag_of(zr_q);
			end
			etfp_pkg::ST_PMAG: begin
				mul_req.a = p_clamp;
				mul_req.b = etfp_pkg::SQRT6;
			end
			etfp_pkg::ST_DONE: load_out = !res_valid_q || result.ready;
			default: ;
		endcase
	end

	assign accept = pixel.valid && pixel.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= etfp_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	// working registers, payload only
	always_ff @(posedge clk) begin
		if (accept) begin
			row_q   <= pixel.row_index;
			col_q   <= pixel.column_index;
			zr_q    <= '0;
			zi_q    <= '0;
			count_q <= '0;
		end
		case (state_q)
			etfp_pkg::ST_CI:  cr_q <= sat_wide(c_sum);
			etfp_pkg::ST_CC:  ci_q <= sat_wide(c_sum);
			etfp_pkg::ST_SQI: sr_q <= sq_val;
			etfp_pkg::ST_PRD: si_q <= sq_val;
			etfp_pkg::ST_PMAG: begin
				p_mag_q <= pm;
				p_neg_q <= zr_q[VB-1] ^ zi_q[VB-1];
			end
			etfp_pkg::ST_UPD: begin
				zr_q    <= nr_fin;
				zi_q    <= ni_fin;
				count_q <= count_next;
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (load_out)
			res_valid_q <= 1'b1;
		else if (result.ready)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			res_row_q   <= row_q;
			res_col_q   <= col_q;
			res_count_q <= count_q;
		end
	end

	assign result.valid           = res_valid_q;
	assign result.out_row         = res_row_q;
	assign result.out_column      = res_col_q;
	assign result.iteration_count = res_count_q;

	// a taken pixel always starts the coordinate set-up
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == etfp_pkg::ST_CR)
		else $error("pixel beat taken without starting set-up");

	// a finished result waits while the previous beat is still held
	a_done_waits: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == etfp_pkg::ST_DONE && res_valid_q && !result.ready
		|=> state_q == etfp_pkg::ST_DONE && res_valid_q)
		else $error("result overwritten before its beat was taken");

	// a stalled result beat keeps its count
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !result.ready |=> res_valid_q && $stable(res_count_q))
		else $error("stalled result changed");

endmodule
